// ----- design/lcs_pkg.sv -----
// Shared constants, types and codes for the fully associative LRU cache set.
package lcs_pkg;

    localparam int WAYS      = 16;
    localparam int IDX_W     = $clog2(WAYS);
    localparam int CNT_W     = $clog2(WAYS + 1);
    localparam int ADDR_W    = 48;
    localparam int STAMP_W   = 32;
    localparam int SHIFT_W   = 4;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(6);

    localparam logic OP_ACCESS     = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    typedef logic [IDX_W-1:0]   lcs_idx_t;
    typedef logic [ADDR_W-1:0]  lcs_block_t;
    typedef logic [STAMP_W-1:0] lcs_stamp_t;

    // One way as read back from the store.
    typedef struct packed {
        logic       valid;
        lcs_block_t block;
        lcs_stamp_t stamp;
    } lcs_rd_t;

    // One write into the store.
    typedef struct packed {
        logic       en;
        lcs_idx_t   idx;
        logic       valid;
        lcs_block_t block;
        lcs_stamp_t stamp;
    } lcs_wr_t;

    // Running result of the scan over the ways.
    typedef struct packed {
        logic       hit_found;
        lcs_idx_t   hit_idx;
        logic       inv_found;
        lcs_idx_t   inv_idx;
        logic       min_found;
        lcs_idx_t   min_idx;
        lcs_stamp_t min_stamp;
        lcs_block_t min_block;
    } lcs_track_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } lcs_state_t;

endpackage

// ----- design/lcs_way_store.sv -----
// Way storage: valid flags in flip-flops, block and stamp in a registered-read memory.
module lcs_way_store (
    input  logic            aclk,
    input  logic            aresetn,
    input  lcs_pkg::lcs_idx_t rd_idx,
    input  lcs_pkg::lcs_wr_t  wr,
    output lcs_pkg::lcs_rd_t  rd
);
    import lcs_pkg::*;

    logic [WAYS-1:0] valid_reg;
    lcs_block_t      block_mem [WAYS];
    lcs_stamp_t      stamp_mem [WAYS];
    lcs_rd_t         rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.idx] <= wr.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            block_mem[wr.idx] <= wr.block;
            stamp_mem[wr.idx] <= wr.stamp;
        end
        rd_reg.valid <= valid_reg[rd_idx];
        rd_reg.block <= block_mem[rd_idx];
        rd_reg.stamp <= stamp_mem[rd_idx];
    end

    assign rd = rd_reg;

endmodule

// ----- design/lcs_scan_unit.sv -----
// Shared compare unit: folds one way into the running hit, free-way and oldest-stamp search.
module lcs_scan_unit (
    input  lcs_pkg::lcs_rd_t    rd,
    input  lcs_pkg::lcs_idx_t   idx,
    input  lcs_pkg::lcs_block_t blk,
    input  lcs_pkg::lcs_track_t cur,
    output lcs_pkg::lcs_track_t nxt
);
    import lcs_pkg::*;

    always_comb begin
        nxt = cur;
        if (rd.valid && (rd.block == blk) && !cur.hit_found) begin
            nxt.hit_found = 1'b1;
            nxt.hit_idx   = idx;
        end
        if (!rd.valid && !cur.inv_found) begin
            nxt.inv_found = 1'b1;
            nxt.inv_idx   = idx;
        end
        // Strict less-than keeps the lowest-numbered way among equal stamps.
        if (rd.valid && (!cur.min_found || (rd.stamp < cur.min_stamp))) begin
            nxt.min_found = 1'b1;
            nxt.min_idx   = idx;
            nxt.min_stamp = rd.stamp;
            nxt.min_block = rd.block;
        end
    end

endmodule

// ----- design/lru_cache_set_core.sv -----
// Top level of the fully associative LRU cache set: sequencer, request and result registers.
//
//  Channel  | Direction | Handshake        | Payload
//  ---------+-----------+------------------+-------------------------------------------
//  s_       | in        | s_valid/s_ready  | s_opcode, s_address, s_stamp
//  m_       | out       | m_valid/m_ready  | m_hit, m_evicted_valid, m_evicted_block
//  cfg_     | in        | cfg_wr_en        | cfg_wr_data (block_size_log2)
//
// Each request passes in turn through taking the request, a scan in which the
// single compare unit examines one way per cycle through the registered read
// port of the way store, and a step that writes the chosen way and loads the result.
// Reset clears the sequencer, the result valid flag, all way valid flags and sets
// the block size shift to six; no clearing pass is needed.
// A stalled result holds the block in its update step until the result is taken,
// but a new request is accepted while the previous result still waits.
module lru_cache_set_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [lcs_pkg::SHIFT_W-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_opcode,
    input  logic [lcs_pkg::ADDR_W-1:0]  s_address,
    input  logic [lcs_pkg::STAMP_W-1:0] s_stamp,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic                   m_evicted_valid,
    output logic [lcs_pkg::ADDR_W-1:0]  m_evicted_block
);
    import lcs_pkg::*;

    // Configuration register holding the address shift.
    logic [SHIFT_W-1:0] shift_reg;

    // Sequencer state and the latched request.
    lcs_state_t  state_reg, state_next;
    logic        op_reg, op_next;
    lcs_block_t  blk_reg, blk_next;
    lcs_stamp_t  stamp_reg, stamp_next;

    // The issue counter addresses the store; the check flag marks read data
    // that has come back for the way held in chk_idx_reg.
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_reg, chk_next;
    lcs_idx_t         chk_idx_reg, chk_idx_next;
    lcs_track_t       track_reg, track_next, track_fold;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic        hit_reg, hit_next;
    logic        ev_valid_reg, ev_valid_next;
    lcs_block_t  ev_block_reg, ev_block_next;

    lcs_rd_t     rd;
    lcs_wr_t     wr;
    logic        accept;
    logic        out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    lcs_way_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (iss_reg[IDX_W-1:0]),
        .wr      (wr),
        .rd      (rd)
    );

    lcs_scan_unit u_scan (
        .rd  (rd),
        .idx (chk_idx_reg),
        .blk (blk_reg),
        .cur (track_reg),
        .nxt (track_fold)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        blk_next      = blk_reg;
        stamp_next    = stamp_reg;
        iss_next      = iss_reg;
        chk_next      = 1'b0;
        chk_idx_next  = chk_idx_reg;
        track_next    = track_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        hit_next      = hit_reg;
        ev_valid_next = ev_valid_reg;
        ev_block_next = ev_block_reg;
        wr            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // The block address is formed once, as the request is taken.
                    op_next    = s_opcode;
                    blk_next   = s_address >> shift_reg;
                    stamp_next = s_stamp;
                    iss_next   = '0;
                    track_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (iss_reg < CNT_W'(WAYS)) begin
                    iss_next     = iss_reg + CNT_W'(1);
                    chk_next     = 1'b1;
                    chk_idx_next = iss_reg[IDX_W-1:0];
                end
                if (chk_reg) begin
                    track_next = track_fold;
                    if (chk_idx_reg == IDX_W'(WAYS - 1)) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    hit_next      = track_reg.hit_found;
                    ev_valid_next = 1'b0;
                    ev_block_next = '0;
                    state_next    = ST_IDLE;
                    if (op_reg == OP_INVALIDATE) begin
                        // A matching way is cleared: its valid flag, block and stamp all go to zero.
                        wr.en    = track_reg.hit_found;
                        wr.idx   = track_reg.hit_idx;
                        wr.valid = 1'b0;
                        wr.block = '0;
                        wr.stamp = '0;
                    end else if (track_reg.hit_found) begin
                        wr.en    = 1'b1;
                        wr.idx   = track_reg.hit_idx;
                        wr.valid = 1'b1;
                        wr.block = blk_reg;
                        wr.stamp = stamp_reg;
                    end else begin
                        // Miss: a free way wins over the oldest valid way.
                        wr.en    = 1'b1;
                        wr.valid = 1'b1;
                        wr.block = blk_reg;
                        wr.stamp = stamp_reg;
                        if (track_reg.inv_found) begin
                            wr.idx = track_reg.inv_idx;
                        end else begin
                            wr.idx        = track_reg.min_idx;
                            ev_valid_next = 1'b1;
                            ev_block_next = track_reg.min_block;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chk_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            shift_reg   <= SHIFT_RESET;
        end else begin
            state_reg   <= state_next;
            chk_reg     <= chk_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                shift_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        stamp_reg    <= stamp_next;
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        track_reg    <= track_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_block_reg <= ev_block_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_hit           = hit_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_block = ev_block_reg;

endmodule

// ----- design/lcs_checker.sv -----
// Port-level checker for the LRU cache set, bound to the top level.
module lcs_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_hit,
    input logic                   m_evicted_valid,
    input logic [lcs_pkg::ADDR_W-1:0]  m_evicted_block
);
    import lcs_pkg::*;

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_evicted_valid)
            && $stable(m_evicted_block))
        else $error("result changed while stalled");

    // An eviction only comes from a miss.
    a_evict_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_evicted_valid |-> !m_hit)
        else $error("eviction reported on a hit");

    // With no eviction the block field reads zero.
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_evicted_valid |-> (m_evicted_block == '0))
        else $error("evicted block not zero");

    // The block is busy in the cycle after taking a request.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

endmodule

bind lru_cache_set_core lcs_checker u_lcs_checker (.*);

// ----- sim/lru_cache_set_checker.sv -----
// Checker for the LRU cache set: follows the channels, predicts every result and compares it.
module lru_cache_set_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lcs_pkg::SHIFT_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_opcode,
    input  lcs_pkg::lcs_block_t         s_address,
    input  lcs_pkg::lcs_stamp_t         s_stamp,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_hit,
    input  logic                        m_evicted_valid,
    input  lcs_pkg::lcs_block_t         m_evicted_block,
    output int                          fail_count,
    output int                          results_waiting,
    output int                          results_seen,
    output int                          hits_seen,
    output int                          evictions_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    localparam int NO_WAY = -1;

    typedef struct packed {
        logic       hit;
        logic       evicted_valid;
        lcs_block_t evicted_block;
    } cache_outcome_t;

    // Shadow copy of the ways and of the shift register.
    lcs_block_t         tag_q   [WAYS];
    logic               valid_q [WAYS];
    lcs_stamp_t         age_q   [WAYS];
    logic [SHIFT_W-1:0] shift_q;
    cache_outcome_t     expected_outcomes [$];

    // Applies one request to the shadow ways and returns the outcome it must produce.
    function automatic cache_outcome_t lookup_and_replace(input logic op,
                                                          input lcs_block_t addr,
                                                          input lcs_stamp_t stamp);
        cache_outcome_t res;
        lcs_block_t     blk;
        int             way;
        int             victim;
        res = '0;
        blk = addr >> shift_q;
        way = NO_WAY;
        for (int w = 0; w < WAYS; w++) begin
            if (way == NO_WAY && valid_q[w] && tag_q[w] == blk) way = w;
        end
        if (op == OP_INVALIDATE) begin
            if (way != NO_WAY) begin
                valid_q[way] = 1'b0;
                age_q[way]   = '0;
                tag_q[way]   = '0;
                res.hit      = 1'b1;
            end
            return res;
        end
        if (way != NO_WAY) begin
            age_q[way] = stamp;
            res.hit    = 1'b1;
            return res;
        end
        // An empty way is always preferred; otherwise the lowest stamp, lowest way on a tie.
        victim = NO_WAY;
        for (int w = 0; w < WAYS; w++) begin
            if (victim == NO_WAY && !valid_q[w]) victim = w;
        end
        if (victim == NO_WAY) begin
            victim = 0;
            for (int w = 1; w < WAYS; w++) begin
                if (age_q[w] < age_q[victim]) victim = w;
            end
            res.evicted_valid = 1'b1;
            res.evicted_block = tag_q[victim];
        end
        tag_q[victim]   = blk;
        valid_q[victim] = 1'b1;
        age_q[victim]   = stamp;
        return res;
    endfunction

    always @(posedge aclk) begin
        cache_outcome_t got;
        cache_outcome_t want;
        if (!aresetn) begin
            shift_q = SHIFT_RESET;
            foreach (tag_q[w]) begin
                tag_q[w]   = '0;
                valid_q[w] = 1'b0;
                age_q[w]   = '0;
            end
            expected_outcomes.delete();
            fail_count      = 0;
            results_waiting = 0;
            results_seen    = 0;
            hits_seen       = 0;
            evictions_seen  = 0;
        end else begin
            if (cfg_wr_en) shift_q = cfg_wr_data;
            // The result side goes first, so a request taken at this edge is never
            // matched against a result that left at the same edge.
            if (m_valid && m_ready) begin
                got.hit           = m_hit;
                got.evicted_valid = m_evicted_valid;
                got.evicted_block = m_evicted_block;
                results_seen++;
                if (got.hit) hits_seen++;
                if (got.evicted_valid) evictions_seen++;
                if (expected_outcomes.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                        fail_count++;
                    end
                    if (got.evicted_valid !== want.evicted_valid) begin
                        $error("evicted_valid: expected %0d, actual %0d",
                               want.evicted_valid, got.evicted_valid);
                        fail_count++;
                    end
                    if (got.evicted_block !== want.evicted_block) begin
                        $error("evicted_block: expected %h, actual %h",
                               want.evicted_block, got.evicted_block);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_outcomes.push_back(lookup_and_replace(s_opcode, s_address, s_stamp));
            end
            results_waiting = expected_outcomes.size();
        end
    end

endmodule

// ----- sim/lru_cache_set_core_tb.sv -----
// Testbench top for the LRU cache set: drives requests and block-size settings, gives the verdict.
module lru_cache_set_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    // Seven random phases plus the directed opening make up roughly five hundred requests.
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 68;
    localparam int POOL_MAX        = 40;
    localparam int HOT_BLOCKS      = 12;
    // SETTLE_CYCLES spans one full request; that many quiet cycles lets the block settle.
    localparam int SETTLE_CYCLES   = WAYS + 3;
    localparam int DRAIN_CYCLES    = 4 * (WAYS + 3);
    // Far beyond the longest quiet spell of a correct run: the longest sender gap, the
    // longest receiver stall, a full request and the pause before a register write.
    localparam int WATCHDOG_LIMIT  = 2000;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [SHIFT_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic               s_opcode    = OP_ACCESS;
    lcs_block_t         s_address   = '0;
    lcs_stamp_t         s_stamp     = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic               m_hit;
    logic               m_evicted_valid;
    lcs_block_t         m_evicted_block;

    int fail_count;
    int results_waiting;
    int results_seen;
    int hits_seen;
    int evictions_seen;

    int         requests_sent = 0;
    int         burst_left    = 0;
    int         ready_left    = 0;
    int         quiet_cycles  = 0;
    lcs_stamp_t clock_now     = '0;

    lru_cache_set_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_address       (s_address),
        .s_stamp         (s_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_block (m_evicted_block)
    );

    // The checker sits beside the block, watching both channels and the register port.
    lru_cache_set_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_address       (s_address),
        .s_stamp         (s_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_block (m_evicted_block),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .results_seen    (results_seen),
        .hits_seen       (hits_seen),
        .evictions_seen  (evictions_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The receiver runs its own pattern: short stalls, short bursts of readiness and
    // long stretches in which every result is taken at once. It changes only on the
    // falling edge, so the block always sees a settled value at the rising edge.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 3))
                0: begin
                    m_ready    <= 1'b0;
                    ready_left = $urandom_range(1, 20);
                end
                1: begin
                    m_ready    <= 1'b1;
                    ready_left = $urandom_range(40, 120);
                end
                default: begin
                    m_ready    <= 1'b1;
                    ready_left = $urandom_range(1, 8);
                end
            endcase
        end
        ready_left--;
    end

    // The watchdog counts cycles without any transfer on either channel. A correct
    // run never comes near the limit, so reaching it means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic lcs_block_t random_address();
        return lcs_block_t'({$urandom(), $urandom()});
    endfunction

    // Sends one request. The sender works in bursts: when a burst runs out it drops
    // valid for a random gap that is never empty, so that valid is never lowered and
    // raised in the same step. Within a burst valid stays high from one transfer to
    // the next and only the payload changes.
    task automatic send_request(input logic op, input lcs_block_t addr,
                                input lcs_stamp_t stamp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_address <= addr;
        s_stamp   <= stamp;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
    endtask

    // A new block size is only written with the block idle: every result has been
    // taken and the block has had a full request time to go back to rest.
    task automatic write_block_shift(input logic [SHIFT_W-1:0] value);
        s_valid    <= 1'b0;
        burst_left = 0;
        while (results_waiting != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Directed opening under the reset block size. It walks through an empty-way fill,
    // a hit within the same block, invalidation of a present and of an absent block,
    // the largest address and stamp, a full set with two ways tied on the oldest stamp,
    // the eviction of the lower of the tied pair, a refill into a freshly cleared way
    // and a hit whose stamp is smaller than the one already recorded.
    task automatic run_directed();
        lcs_block_t top_addr;
        lcs_stamp_t fill_stamp;
        top_addr = '1;
        send_request(OP_ACCESS, '0, lcs_stamp_t'(0));
        send_request(OP_ACCESS, lcs_block_t'(48'h3F), lcs_stamp_t'(1));
        send_request(OP_INVALIDATE, lcs_block_t'(48'h20), lcs_stamp_t'(2));
        send_request(OP_INVALIDATE, '0, lcs_stamp_t'(3));
        send_request(OP_ACCESS, top_addr, '1);
        for (int w = 1; w < WAYS; w++) begin
            fill_stamp = (w <= 2) ? lcs_stamp_t'(5) : lcs_stamp_t'(10 + w);
            send_request(OP_ACCESS, lcs_block_t'(w) << SHIFT_RESET, fill_stamp);
        end
        send_request(OP_ACCESS, lcs_block_t'(100) << SHIFT_RESET, lcs_stamp_t'(20));
        send_request(OP_ACCESS, lcs_block_t'(101) << SHIFT_RESET, lcs_stamp_t'(21));
        send_request(OP_INVALIDATE, lcs_block_t'(7) << SHIFT_RESET, lcs_stamp_t'(22));
        send_request(OP_ACCESS, lcs_block_t'(102) << SHIFT_RESET, lcs_stamp_t'(23));
        send_request(OP_ACCESS, top_addr - lcs_block_t'(5), lcs_stamp_t'(24));
        clock_now = lcs_stamp_t'(30);
    endtask

    // Random traffic over a working set a little larger than the cache, so that hits,
    // refreshes and evictions all happen often. A hot subset of the working set gives
    // the LRU order something to keep. About one request in ten is an unrelated
    // address, and about one in twenty carries a stamp that breaks the time order.
    task automatic run_random(input int n, input logic [SHIFT_W-1:0] shift);
        lcs_block_t pool [POOL_MAX];
        int         pool_size;
        lcs_block_t blk;
        lcs_block_t offset;
        lcs_block_t addr;
        logic       op;
        lcs_stamp_t stamp;
        pool_size = $urandom_range(18, POOL_MAX);
        foreach (pool[i]) pool[i] = random_address() >> shift;
        pool[0] = lcs_block_t'('1) >> shift;
        pool[1] = '0;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 4) == 0) ? OP_INVALIDATE : OP_ACCESS;
            if ($urandom_range(0, 9) == 0) begin
                addr = random_address();
            end else begin
                blk    = ($urandom_range(0, 9) < 6) ? pool[$urandom_range(0, HOT_BLOCKS - 1)]
                                                    : pool[$urandom_range(0, pool_size - 1)];
                offset = random_address() & ((lcs_block_t'(1) << shift) - lcs_block_t'(1));
                addr   = (blk << shift) | offset;
            end
            if ($urandom_range(0, 19) == 0) begin
                stamp = $urandom();
            end else begin
                clock_now = clock_now + lcs_stamp_t'($urandom_range(0, 3));
                stamp     = clock_now;
            end
            send_request(op, addr, stamp);
        end
    endtask

    initial begin
        logic [SHIFT_W-1:0] shift_plan [N_PHASES];
        // Smallest and largest shifts, the sizes beyond twelve, and a return to the default.
        shift_plan = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd3, 4'd6, 4'($urandom_range(0, 15))};

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        run_directed();
        for (int p = 0; p < N_PHASES - 1; p++) begin
            write_block_shift(shift_plan[p]);
            // One phase starts its clock just short of the top so that the stamps wrap.
            if (p == 3) clock_now = 32'hFFFF_FFC0;
            run_random(ITEMS_PER_PHASE, shift_plan[p]);
        end
        write_block_shift(shift_plan[N_PHASES - 1]);
        run_random(ITEMS_PER_PHASE, shift_plan[N_PHASES - 1]);

        // Stop sending, wait for every outstanding result, then give the block time to
        // show any stray result before the verdict.
        s_valid <= 1'b0;
        while (results_waiting != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d requests over %0d block-size settings, the last being shift %0d.",
                 requests_sent, N_PHASES, shift_plan[N_PHASES - 1]);
        $display("Checked %0d results: %0d hits and %0d evictions of valid blocks.",
                 results_seen, hits_seen, evictions_seen);
        if (fail_count == 0 && results_waiting == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
